// ===== src/ihxs_pkg.sv =====
// Shared constants for the IPv4 header skipping XOR scrambler.
// Holds header field codes, size limits and register indexes; no dependencies.
package ihxs_pkg;

  localparam int unsigned HOLD_DEPTH_DEF = 16;
  localparam int unsigned WORD_BYTES     = 4;

  // configuration register indexes
  localparam logic REG_SKIP_MODE = 1'b0;
  localparam logic REG_XOR_KEY   = 1'b1;

  // skip modes (mode three behaves as transport mode)
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_IP   = 2'd1;

  localparam logic [3:0] IP_VERSION   = 4'd4;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;

  localparam int unsigned MIN_IP_HDR  = 20;
  localparam int unsigned MIN_TCP_HDR = 20;
  localparam int unsigned UDP_HDR     = 8;
  localparam int unsigned PROTO_POS   = 9;   // byte offset of IPv4 protocol field
  localparam int unsigned TCP_OFS_POS = 12;  // byte offset of TCP data offset, from IP end

endpackage

// ===== src/ipv4_header_skipping_xor_scrambler_core.sv =====
// IPv4 header skipping XOR scrambler, top level. Uses ihxs_pkg and ihxs_hold_buf.
// Each output byte is registered in the output register.
// Throughput: one byte per cycle while the output is ready; the TCP data offset byte
// releases the held bytes (up to twelve) plus itself at the same rate; input stalls meanwhile.
// Reset: asynchronous active low, clears position, skip state and both registers.
module ipv4_header_skipping_xor_scrambler_core
  import ihxs_pkg::*;
#(
  parameter int unsigned HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] packet_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_packet_o,
  output logic        burst_end_o
);

  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned AW = $clog2(HOLD_DEPTH);

  logic [1:0]    mode_q;
  logic [7:0]    key_q;
  logic [15:0]   pos_q, pos_d;
  logic [15:0]   len_q, len_d;
  logic [5:0]    ihl_q, ihl_d;
  logic [6:0]    skip_q, skip_d;
  logic          dec_q, dec_d;
  logic [CW-1:0] held_cnt_q, held_cnt_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic          drain_q, drain_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_eop_q, out_eop_d;
  logic          out_bend_q, out_bend_d;
  logic [7:0]    tail_byte_q, tail_byte_d;
  logic          tail_xor_q, tail_xor_d;
  logic          tail_eop_q, tail_eop_d;

  logic          in_fire, slot_free;
  logic          first_c, hdr_ok, dec0, dec1, dec2, end_c, hold_c, start_drain;
  logic [15:0]   len_c;
  logic [5:0]    ihl_raw, ihl_c, thl_c;
  logic [6:0]    skip0, skip1;
  logic [CW-1:0] held_c;
  logic          cur_xor, first_held_xor, drain_xor;
  logic          wr_en;
  logic [7:0]    rd_data;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = !drain_q && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // skip decision for the accepted byte
  always_comb begin
    first_c = (pos_q == 16'd0);
    len_c   = first_c ? packet_length_i : len_q;
    ihl_raw = 6'(data_byte_i[3:0]) * 6'(WORD_BYTES);
    hdr_ok  = (mode_q != MODE_NONE) && (packet_length_i >= 16'(MIN_IP_HDR)) &&
              (data_byte_i[7:4] == IP_VERSION) && (ihl_raw >= 6'(MIN_IP_HDR)) &&
              (packet_length_i >= 16'(ihl_raw));
    ihl_c   = first_c ? (hdr_ok ? ihl_raw : 6'd0) : ihl_q;
    skip0   = first_c ? (hdr_ok ? 7'(ihl_raw) : 7'd0) : skip_q;
    dec0    = first_c ? !(hdr_ok && (mode_q != MODE_IP)) : dec_q;
    held_c  = first_c ? '0 : held_cnt_q;
    thl_c   = 6'(data_byte_i[7:4]) * 6'(WORD_BYTES);
    skip1   = skip0;
    dec1    = dec0;
    if (!dec0 && (pos_q == 16'(PROTO_POS))) begin
      if (data_byte_i == PROTO_TCP) begin
        // too short for a full TCP header: settle on the IP header now
        dec1 = (len_c < 16'(ihl_c) + 16'(MIN_TCP_HDR));
      end else begin
        if ((data_byte_i == PROTO_UDP) && (len_c >= 16'(ihl_c) + 16'(UDP_HDR))) begin
          skip1 = 7'(ihl_c) + 7'(UDP_HDR);
        end
        dec1 = 1'b1;
      end
    end else if (!dec0 && (pos_q == 16'(ihl_c) + 16'(TCP_OFS_POS))) begin
      if ((thl_c >= 6'(MIN_TCP_HDR)) && (len_c >= 16'(ihl_c) + 16'(thl_c))) begin
        skip1 = 7'(ihl_c) + 7'(thl_c);
      end
      dec1 = 1'b1;
    end
    end_c          = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_c};
    hold_c         = !dec1 && (pos_q >= 16'(skip1)) && !end_c;
    dec2           = dec1 || end_c;
    start_drain    = dec2 && (held_c != '0);
    cur_xor        = (pos_q >= 16'(skip1));
    first_held_xor = ({1'b0, ihl_c} >= skip1);
    drain_xor      = (8'(ihl_q) + 8'(rd_ptr_q)) >= {1'b0, skip_q};
  end

  assign wr_en = in_fire && hold_c && (held_c < CW'(HOLD_DEPTH));

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    ihl_d       = ihl_q;
    skip_d      = skip_q;
    dec_d       = dec_q;
    held_cnt_d  = held_cnt_q;
    rd_ptr_d    = rd_ptr_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_eop_d   = out_eop_q;
    out_bend_d  = out_bend_q;
    tail_byte_d = tail_byte_q;
    tail_xor_d  = tail_xor_q;
    tail_eop_d  = tail_eop_q;

    if (in_fire) begin
      len_d  = len_c;
      ihl_d  = ihl_c;
      skip_d = skip1;
      dec_d  = dec2;
      pos_d  = end_c ? 16'd0 : pos_q + 16'd1;
      if (hold_c) begin
        held_cnt_d = held_c + CW'(1);
      end else if (dec2 && !start_drain) begin
        held_cnt_d = '0;
      end else begin
        held_cnt_d = held_c;
      end
    end

    if (in_fire && !hold_c) begin
      out_valid_d = 1'b1;
      if (start_drain) begin
        // first held byte goes out now, the current byte closes the burst
        out_byte_d  = rd_data ^ (first_held_xor ? key_q : 8'h00);
        out_eop_d   = 1'b0;
        out_bend_d  = 1'b0;
        drain_d     = 1'b1;
        rd_ptr_d    = CW'(1);
        tail_byte_d = data_byte_i;
        tail_xor_d  = cur_xor;
        tail_eop_d  = end_c;
      end else begin
        out_byte_d = data_byte_i ^ (cur_xor ? key_q : 8'h00);
        out_eop_d  = end_c;
        out_bend_d = 1'b1;
      end
    end else if (drain_q && slot_free) begin
      out_valid_d = 1'b1;
      if (rd_ptr_q == held_cnt_q) begin
        out_byte_d = tail_byte_q ^ (tail_xor_q ? key_q : 8'h00);
        out_eop_d  = tail_eop_q;
        out_bend_d = 1'b1;
        drain_d    = 1'b0;
        held_cnt_d = '0;
        rd_ptr_d   = '0;
      end else begin
        out_byte_d = rd_data ^ (drain_xor ? key_q : 8'h00);
        out_eop_d  = 1'b0;
        out_bend_d = 1'b0;
        rd_ptr_d   = rd_ptr_q + CW'(1);
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      key_q       <= 8'h00;
      pos_q       <= 16'd0;
      len_q       <= 16'd0;
      ihl_q       <= 6'd0;
      skip_q      <= 7'd0;
      dec_q       <= 1'b0;
      held_cnt_q  <= '0;
      rd_ptr_q    <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SKIP_MODE: mode_q <= cfg_data_i[1:0];
          REG_XOR_KEY:   key_q  <= cfg_data_i;
        endcase
      end
      pos_q       <= pos_d;
      len_q       <= len_d;
      ihl_q       <= ihl_d;
      skip_q      <= skip_d;
      dec_q       <= dec_d;
      held_cnt_q  <= held_cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_eop_q   <= out_eop_d;
    out_bend_q  <= out_bend_d;
    tail_byte_q <= tail_byte_d;
    tail_xor_q  <= tail_xor_d;
    tail_eop_q  <= tail_eop_d;
  end

  ihxs_hold_buf #(
    .DEPTH (HOLD_DEPTH),
    .AW    (AW)
  ) u_hold_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (held_c[AW-1:0]),
    .wr_data_i (data_byte_i),
    .rd_addr_i (rd_ptr_d[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign end_of_packet_o = out_eop_q;
  assign burst_end_o     = out_bend_q;

endmodule

// ===== src/ihxs_hold_buf.sv =====
// Hold buffer for bytes whose scrambling waits on the TCP data offset.
// One write port, one registered read port with write bypass; no dependencies.
module ihxs_hold_buf #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port follows the address every cycle; a same-cycle write is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
